[sv/cswpt_pkg.sv]
// shared types, constants and helper functions for the pixel test pipeline
`default_nettype none

package cswpt_pkg;

    localparam int SAMPLE_BITS = 16;

    // widths of the intermediate values
    localparam int DIFF_W  = SAMPLE_BITS + 1;     // band sums and differences
    localparam int VS_W    = SAMPLE_BITS + 2;     // visible sum and whiteness deviations
    localparam int WSUM_W  = SAMPLE_BITS + 3;     // whiteness deviation sum
    localparam int DEN_W   = SAMPLE_BITS + 1;     // divisor width
    localparam int DIV_STEP = 5;                  // quotient bits per divider stage
    localparam int DIV_STG  = (SAMPLE_BITS + 14 + DIV_STEP - 1) / DIV_STEP;
    localparam int QW       = DIV_STG * DIV_STEP; // dividend and quotient width
    localparam int SUM_W    = QW + 2;
    localparam int PROB_W   = 24;

    localparam int ND_SCALE   = 1600;
    localparam int ND_ZERO    = 16;
    localparam int BRIGHT_MAX = 1600;

    // floor(x/11) as (x*REC_M) >> REC_K for x below 2^(SAMPLE_BITS+3)
    localparam int    REC_K  = SAMPLE_BITS + 7;
    localparam int    REC_W  = REC_K - 3;
    localparam longint REC_M = ((64'd1 << REC_K) + 10) / 11;
    localparam int    BR_X_W = SAMPLE_BITS + 3;
    localparam int    BR_W   = BR_X_W + REC_W;

    localparam logic [1:0] WATER_NO      = 2'd0;
    localparam logic [1:0] WATER_YES     = 2'd1;
    localparam logic [1:0] WATER_OUTSIDE = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] blue;
        logic signed [SAMPLE_BITS-1:0] green;
        logic signed [SAMPLE_BITS-1:0] red;
        logic signed [SAMPLE_BITS-1:0] near_ir;
        logic signed [SAMPLE_BITS-1:0] short_ir;
        logic signed [SAMPLE_BITS-1:0] band_seven;
        logic                          blue_saturated;
        logic                          green_saturated;
        logic                          red_saturated;
        logic                          pixel_valid;
    } t_in_word;

    typedef struct packed {
        logic                     potential_cloud;
        logic                     snow_flag;
        logic [1:0]               water_code;
        logic                     clear_pixel;
        logic signed [PROB_W-1:0] land_prob;
        logic signed [PROB_W-1:0] water_prob;
    } t_out_word;

    typedef struct packed {
        logic signed [DIFF_W-1:0]      vnum;
        logic signed [DIFF_W-1:0]      vden;
        logic signed [DIFF_W-1:0]      snum;
        logic signed [DIFF_W-1:0]      sden;
        logic signed [VS_W-1:0]        vs;
        logic signed [VS_W-1:0]        d1;
        logic signed [VS_W-1:0]        d2;
        logic signed [VS_W-1:0]        d3;
        logic signed [SAMPLE_BITS-1:0] b5;
        logic signed [SAMPLE_BITS-1:0] b7;
        logic                          b7_gt300;
        logic                          b7_gt100;
        logic                          haze_ok;
        logic                          ratio45_ok;
        logic                          b4_gt1100;
        logic                          b2_gt1000;
        logic                          b4_lt1100;
        logic                          b4_lt500;
        logic                          sat1;
        logic                          sat2;
        logic                          sat3;
        logic                          pixel_valid;
    } t_stage1;

    typedef struct packed {
        logic                          pc_base;
        logic                          b7_gt100;
        logic                          snow;
        logic                          water;
        logic                          pixel_valid;
        logic                          v_zero;
        logic                          v_kill;
        logic                          s_zero;
        logic                          s_kill;
        logic                          w_zero;
        logic                          w_huge;
        logic signed [SAMPLE_BITS-1:0] b7;
        logic [BR_W-1:0]               bright_prod;
    } t_side;

    // num/den < a/b with b > 0, a zero den makes the ratio count as 0.01
    function automatic logic ratio_lt(input logic signed [DIFF_W-1:0] num,
                                      input logic signed [DIFF_W-1:0] den,
                                      input int a, input int b);
        logic signed [DIFF_W+8:0] lhs;
        logic signed [DIFF_W+8:0] rhs;
        logic                     res;
        lhs = (DIFF_W+9)'(num) * (DIFF_W+9)'(b);
        rhs = (DIFF_W+9)'(den) * (DIFF_W+9)'(a);
        if (den == '0) begin
            res = (b < a * 100);
        end else if (den > 0) begin
            res = (lhs < rhs);
        end else begin
            res = (lhs > rhs);
        end
        return res;
    endfunction

    function automatic logic ratio_gt(input logic signed [DIFF_W-1:0] num,
                                      input logic signed [DIFF_W-1:0] den,
                                      input int a, input int b);
        logic signed [DIFF_W+8:0] lhs;
        logic signed [DIFF_W+8:0] rhs;
        logic                     res;
        lhs = (DIFF_W+9)'(num) * (DIFF_W+9)'(b);
        rhs = (DIFF_W+9)'(den) * (DIFF_W+9)'(a);
        if (den == '0) begin
            res = (b > a * 100);
        end else if (den > 0) begin
            res = (lhs > rhs);
        end else begin
            res = (lhs < rhs);
        end
        return res;
    endfunction

    function automatic logic signed [PROB_W-1:0] sat_prob(input logic signed [SUM_W-1:0] v);
        logic signed [PROB_W-1:0] res;
        if (v > SUM_W'(8388607)) begin
            res = PROB_W'(8388607);
        end else if (v < SUM_W'(-8388608)) begin
            res = PROB_W'(-8388608);
        end else begin
            res = v[PROB_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/cswpt_div.sv]
// pipelined restoring divider, a few quotient bits per stage
`default_nettype none

module cswpt_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 17,
    parameter int STEP  = 5,
    parameter int STG   = 6
) (
    input  wire logic             i_clk,
    input  wire logic [STG-1:0]   i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);

    // r_num shifts the dividend out at the top and the quotient in at the bottom
    logic [NUM_W-1:0] r_num [STG];
    logic [DEN_W:0]   r_rem [STG];
    logic [DEN_W-1:0] r_den [STG];

    for (genvar k = 0; k < STG; k++) begin : g_stage
        logic [NUM_W-1:0] s_num;
        logic [DEN_W:0]   s_rem;
        logic [DEN_W-1:0] s_den;
        logic [NUM_W-1:0] n_num;
        logic [DEN_W:0]   n_rem;

        if (k == 0) begin : g_first
            assign s_num = i_num;
            assign s_rem = '0;
            assign s_den = i_den;
        end else begin : g_next
            assign s_num = r_num[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
        end

        always_comb begin
            logic [NUM_W-1:0] num;
            logic [DEN_W:0]   rem;
            num = s_num;
            rem = s_rem;
            for (int j = 0; j < STEP; j++) begin
                rem = {rem[DEN_W-1:0], num[NUM_W-1]};
                num = {num[NUM_W-2:0], 1'b0};
                if (rem >= {1'b0, s_den}) begin
                    rem    = rem - {1'b0, s_den};
                    num[0] = 1'b1;
                end
            end
            n_num = num;
            n_rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_num[k] <= n_num;
                r_rem[k] <= n_rem;
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quo = r_num[STG-1];

endmodule

`default_nettype wire

[sv/cloud_snow_water_pixel_test.sv]
// top level: per-pixel potential cloud, snow and water tests with cloud probabilities
`default_nettype none

// One pixel word enters per clock while o_stall is low, and its result word leaves
// after passing through an input register, two preparation stages, the
// divider stages that form the NDVI, NDSI and whiteness probability terms (three
// pipelined restoring dividers, five quotient bits per stage), and the output
// register. Each stage holds its word until the next stage is free, so bubbles
// close up under stall and words are never dropped or repeated. cirrus_mode is
// sampled while words pass through; write it only when the pipeline is empty.
module cloud_snow_water_pixel_test
    import cswpt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_word     o_data,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data
);

    localparam int NS     = DIV_STG + 4;
    localparam int DIV_LO = 3;

    logic          r_cirrus_mode;
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    t_in_word        r_in;
    t_stage1         r_s1;
    t_stage1         n_s1;
    t_side           r_side2;
    t_side           n_side2;
    t_side           r_side [DIV_STG];
    logic [QW-1:0]   r_vn_num, r_sn_num, r_w_num;
    logic [DEN_W-1:0] r_vn_den, r_sn_den, r_w_den;
    logic [QW-1:0]   n_vn_num, n_sn_num, n_w_num;
    logic [DEN_W-1:0] n_vn_den, n_sn_den, n_w_den;
    logic [QW-1:0]   w_qv, w_qs, w_qw;
    t_out_word       r_out;
    t_out_word       n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cirrus_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_cirrus_mode <= i_cfg_wr_data;
        end
    end

    // a stage may load when it is empty or its word moves on
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= i_data;
        end
    end

    // stage 1: band sums, differences and simple threshold compares
    always_comb begin
        logic signed [SAMPLE_BITS-1:0] b1, b2, b3, b4, b5, b7;
        logic signed [SAMPLE_BITS+2:0] b4x4, b5x3;
        b1 = r_in.blue;
        b2 = r_in.green;
        b3 = r_in.red;
        b4 = r_in.near_ir;
        b5 = r_in.short_ir;
        b7 = r_in.band_seven;
        b4x4 = (SAMPLE_BITS+3)'(b4) <<< 2;
        b5x3 = ((SAMPLE_BITS+3)'(b5) <<< 1) + (SAMPLE_BITS+3)'(b5);
        n_s1.vnum = DIFF_W'(b4) - DIFF_W'(b3);
        n_s1.vden = DIFF_W'(b4) + DIFF_W'(b3);
        n_s1.snum = DIFF_W'(b2) - DIFF_W'(b5);
        n_s1.sden = DIFF_W'(b2) + DIFF_W'(b5);
        n_s1.vs   = VS_W'(b1) + VS_W'(b2) + VS_W'(b3);
        n_s1.d1   = (VS_W'(b1) <<< 1) - VS_W'(b2) - VS_W'(b3);
        n_s1.d2   = (VS_W'(b2) <<< 1) - VS_W'(b1) - VS_W'(b3);
        n_s1.d3   = (VS_W'(b3) <<< 1) - VS_W'(b1) - VS_W'(b2);
        n_s1.b5   = b5;
        n_s1.b7   = b7;
        n_s1.b7_gt300   = b7 > SAMPLE_BITS'(300);
        n_s1.b7_gt100   = b7 > SAMPLE_BITS'(100);
        n_s1.haze_ok    = ((VS_W'(b1) <<< 1) - VS_W'(b3)) > VS_W'(1600);
        n_s1.ratio45_ok = (b5 > SAMPLE_BITS'(0)) && (b4x4 > b5x3);
        n_s1.b4_gt1100  = b4 > SAMPLE_BITS'(1100);
        n_s1.b2_gt1000  = b2 > SAMPLE_BITS'(1000);
        n_s1.b4_lt1100  = b4 < SAMPLE_BITS'(1100);
        n_s1.b4_lt500   = b4 < SAMPLE_BITS'(500);
        n_s1.sat1       = r_in.blue_saturated;
        n_s1.sat2       = r_in.green_saturated;
        n_s1.sat3       = r_in.red_saturated;
        n_s1.pixel_valid = r_in.pixel_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: ratio tests, flags, divider operands, short-ir brightness product
    always_comb begin
        logic [VS_W-1:0]        a1, a2, a3;
        logic [WSUM_W-1:0]      wsum;
        logic [WSUM_W+3:0]      wsum10;
        logic [WSUM_W+3:0]      vs7;
        logic                   satv, vs_pos, white_ok;
        logic [DIFF_W-1:0]      nv, dv, ns, ds;
        logic [BR_X_W-1:0]      bx;
        a1 = r_s1.d1[VS_W-1] ? VS_W'(-r_s1.d1) : VS_W'(r_s1.d1);
        a2 = r_s1.d2[VS_W-1] ? VS_W'(-r_s1.d2) : VS_W'(r_s1.d2);
        a3 = r_s1.d3[VS_W-1] ? VS_W'(-r_s1.d3) : VS_W'(r_s1.d3);
        wsum   = WSUM_W'(a1) + WSUM_W'(a2) + WSUM_W'(a3);
        satv   = r_s1.sat1 || r_s1.sat2 || r_s1.sat3;
        vs_pos = r_s1.vs > VS_W'(0);
        wsum10 = (WSUM_W+4)'(wsum) * (WSUM_W+4)'(10);
        vs7    = (WSUM_W+4)'(r_s1.vs[VS_W-2:0]) * (WSUM_W+4)'(7);
        white_ok = satv || (vs_pos && (wsum10 < vs7));

        n_side2.pc_base = ratio_lt(r_s1.snum, r_s1.sden, 4, 5)
                       && ratio_lt(r_s1.vnum, r_s1.vden, 4, 5)
                       && r_s1.b7_gt300 && white_ok
                       && (r_s1.haze_ok || satv) && r_s1.ratio45_ok;
        n_side2.b7_gt100 = r_s1.b7_gt100;
        n_side2.snow = ratio_gt(r_s1.snum, r_s1.sden, 3, 20)
                    && r_s1.b4_gt1100 && r_s1.b2_gt1000;
        n_side2.water = (ratio_lt(r_s1.vnum, r_s1.vden, 1, 100) && r_s1.b4_lt1100)
                     || (ratio_lt(r_s1.vnum, r_s1.vden, 1, 10)
                         && ratio_gt(r_s1.vnum, r_s1.vden, 0, 1) && r_s1.b4_lt500);
        n_side2.pixel_valid = r_s1.pixel_valid;
        n_side2.v_zero = r_s1.vden == '0;
        n_side2.v_kill = r_s1.sat3 && ratio_gt(r_s1.vnum, r_s1.vden, 0, 1);
        n_side2.s_zero = r_s1.sden == '0;
        n_side2.s_kill = r_s1.sat2 && ratio_lt(r_s1.snum, r_s1.sden, 0, 1);
        n_side2.w_zero = satv || r_s1.vs[VS_W-1] || ((r_s1.vs == '0) && (wsum == '0));
        n_side2.w_huge = !satv && (r_s1.vs == '0) && (wsum != '0);
        n_side2.b7     = r_s1.b7;

        // short-ir brightness, floor(16*b5/11) by reciprocal
        bx = {r_s1.b5[SAMPLE_BITS-2:0], 4'b0000};
        if (r_s1.b5 > SAMPLE_BITS'(0)) begin
            n_side2.bright_prod = BR_W'(bx) * BR_W'(REC_M);
        end else begin
            n_side2.bright_prod = '0;
        end

        nv = r_s1.vnum[DIFF_W-1] ? DIFF_W'(-r_s1.vnum) : DIFF_W'(r_s1.vnum);
        dv = r_s1.vden[DIFF_W-1] ? DIFF_W'(-r_s1.vden) : DIFF_W'(r_s1.vden);
        ns = r_s1.snum[DIFF_W-1] ? DIFF_W'(-r_s1.snum) : DIFF_W'(r_s1.snum);
        ds = r_s1.sden[DIFF_W-1] ? DIFF_W'(-r_s1.sden) : DIFF_W'(r_s1.sden);
        n_vn_num = QW'(nv) * QW'(ND_SCALE);
        n_sn_num = QW'(ns) * QW'(ND_SCALE);
        n_w_num  = QW'(wsum) * QW'(ND_SCALE);
        // a zero divisor or a non-positive visible sum is patched to one, the term is overridden later
        n_vn_den = (dv == '0) ? DEN_W'(1) : DEN_W'(dv);
        n_sn_den = (ds == '0) ? DEN_W'(1) : DEN_W'(ds);
        n_w_den  = vs_pos ? DEN_W'(r_s1.vs[VS_W-2:0]) : DEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_side2  <= n_side2;
            r_vn_num <= n_vn_num;
            r_vn_den <= n_vn_den;
            r_sn_num <= n_sn_num;
            r_sn_den <= n_sn_den;
            r_w_num  <= n_w_num;
            r_w_den  <= n_w_den;
        end
    end

    cswpt_div #(
        .NUM_W (QW),
        .DEN_W (DEN_W),
        .STEP  (DIV_STEP),
        .STG   (DIV_STG)
    ) u_div_ndvi (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_LO +: DIV_STG]),
        .i_num (r_vn_num),
        .i_den (r_vn_den),
        .o_quo (w_qv)
    );

    cswpt_div #(
        .NUM_W (QW),
        .DEN_W (DEN_W),
        .STEP  (DIV_STEP),
        .STG   (DIV_STG)
    ) u_div_ndsi (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_LO +: DIV_STG]),
        .i_num (r_sn_num),
        .i_den (r_sn_den),
        .o_quo (w_qs)
    );

    cswpt_div #(
        .NUM_W (QW),
        .DEN_W (DEN_W),
        .STEP  (DIV_STEP),
        .STG   (DIV_STG)
    ) u_div_white (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_LO +: DIV_STG]),
        .i_num (r_w_num),
        .i_den (r_w_den),
        .o_quo (w_qw)
    );

    // flags ride alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en[DIV_LO]) begin
            r_side[0] <= r_side2;
        end
        for (int k = 1; k < DIV_STG; k++) begin
            if (w_en[DIV_LO+k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // final stage: pick terms, combine probabilities, saturate
    always_comb begin
        t_side                  sd;
        logic [QW-1:0]          tv, ts, tw, m;
        logic signed [SUM_W-1:0] thin, land_sum, wat_sum;
        logic [BR_W-REC_K-1:0]  br_q;
        logic [QW-1:0]          bright;
        logic                   pc;
        sd = r_side[DIV_STG-1];
        tv = sd.v_kill ? '0 : (sd.v_zero ? QW'(ND_ZERO) : w_qv);
        ts = sd.s_kill ? '0 : (sd.s_zero ? QW'(ND_ZERO) : w_qs);
        tw = sd.w_zero ? '0 : w_qw;
        m  = (tv > ts) ? tv : ts;
        if (tw > m) begin
            m = tw;
        end
        thin = r_cirrus_mode ? (SUM_W'(sd.b7) <<< 2) : '0;
        br_q = sd.bright_prod[BR_W-1:REC_K];
        bright = (QW'(br_q) > QW'(BRIGHT_MAX)) ? QW'(BRIGHT_MAX) : QW'(br_q);
        land_sum = SUM_W'(ND_SCALE) - $signed({2'b00, m}) + thin;
        wat_sum  = $signed({2'b00, bright}) + thin;
        pc = sd.pc_base || (r_cirrus_mode && sd.b7_gt100);

        n_out.potential_cloud = pc;
        n_out.snow_flag       = sd.snow;
        n_out.water_code      = !sd.pixel_valid ? WATER_OUTSIDE
                              : (sd.water ? WATER_YES : WATER_NO);
        n_out.clear_pixel     = sd.pixel_valid && !pc;
        // zero visible sum with nonzero spread and no saturated band drives land probability to the floor
        n_out.land_prob       = sd.w_huge ? PROB_W'(-8388608) : sat_prob(land_sum);
        n_out.water_prob      = sat_prob(wat_sum);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_data  = r_out;

endmodule

`default_nettype wire
